### sv/rhsi_pkg.sv
// Shared constants and types for the RGB to HSI pixel converter.
// No dependencies.
package rhsi_pkg;

	localparam int CordicSteps = 30;
	localparam int XyWidth     = 34;
	localparam int AngWidth    = 34;
	localparam int SatWidth    = 10;
	localparam logic [20:0] Sqrt3Q20    = 21'd1816187;
	localparam logic signed [AngWidth-1:0] QuarterTurn = 34'sh040000000;
	localparam logic signed [AngWidth-1:0] HalfTurn    = 34'sh080000000;

	typedef logic signed [XyWidth-1:0]  xy_t;
	typedef logic signed [AngWidth-1:0] ang_t;

	typedef struct packed {
		xy_t  x;
		xy_t  y;
		ang_t ang;
	} cordic_t;

	typedef struct packed {
		logic        blue_gt;
		logic        gray;
		logic [7:0]  intensity;
		logic [9:0]  sum;
		logic [9:0]  diff;
	} side_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	// shift right, truncate toward zero
	function automatic xy_t shr_tz(input xy_t v, input logic [4:0] s);
		xy_t a;
		a = v[XyWidth-1] ? -v : v;
		a = a >>> s;
		return v[XyWidth-1] ? -a : a;
	endfunction

endpackage

### sv/rgb_to_hsi_pixel_converter.sv
// Top level of the RGB to HSI pixel converter: stream in, CORDIC pipeline, stream out.
// Depends on rhsi_pkg.
//
// Usage:
//  s_axis carries one pixel per beat, tdata = blue, green, red from bit 0 up.
//  m_axis carries one result per beat, tdata = hue, saturation, intensity from bit 0 up.
//  Every pixel is independent; one beat can enter in every clock.
//  From input beat to output beat a pixel passes two setup stages, one CORDIC
//  rotation per stage (30 stages), a clamp and hue select stage and the
//  output register with the hue scaling.
//  Saturation uses a restoring divider, one quotient bit per stage, run in the
//  CORDIC stages alongside the angle.
//  Throughput: one pixel per cycle unless stalled, set by one rotation per stage.
//  When m_axis_tready is low and m_axis_tvalid is high the whole pipeline holds;
//  s_axis_tready drops only if the output register is full and not being taken.
//  Reset clears all valid bits; payload registers hold garbage until filled.
module rgb_to_hsi_pixel_converter
	import rhsi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // blue[7:0], green[15:8], red[23:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // hue[7:0], saturation[15:8], intensity[23:16]
);

	localparam int Stages = CordicSteps;

	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 1: sums and differences
	logic        v_s1;
	side_t       sd_s1;
	logic [7:0]  mn_s1;
	logic signed [9:0] xr_s1;

	// stage 2: scaled vector, quadrant fold, divider setup
	logic    v_s2;
	side_t   sd_s2;
	cordic_t c_s2;
	logic [SatWidth+7:0] num_s2;

	// CORDIC and divider stages
	logic    v_c  [Stages+1];
	side_t   sd_c [Stages+1];
	cordic_t c_c  [Stages+1];
	logic [17:0] rem_c [Stages+1];
	logic [7:0]  quo_c [Stages+1];

	logic [7:0] bb, gg, rr, mn;
	assign bb = s_axis_tdata[7:0];
	assign gg = s_axis_tdata[15:8];
	assign rr = s_axis_tdata[23:16];

	always_comb begin
		mn = bb;
		if (gg < mn) mn = gg;
		if (rr < mn) mn = rr;
	end

	logic [9:0] sum_in;
	assign sum_in = 10'(bb) + 10'(gg) + 10'(rr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mn_s1 <= mn;
			sd_s1.sum <= sum_in;
			sd_s1.intensity <= 8'((20'(sum_in) * 20'd683) >> 11);
			sd_s1.blue_gt <= bb > gg;
			sd_s1.gray <= (rr == gg) && (gg == bb);
			sd_s1.diff <= (gg >= bb) ? 10'(gg - bb) : 10'(bb - gg);
			xr_s1 <= $signed({1'b0, rr, 1'b0}) - $signed({2'b0, gg}) - $signed({2'b0, bb});
		end
	end

	xy_t x0, y0;
	logic [28:0] yprod;
	assign yprod = 29'(sd_s1.diff[7:0]) * 29'(Sqrt3Q20);
	assign x0 = xy_t'(xr_s1) <<< 20;
	assign y0 = xy_t'(yprod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s2 <= sd_s1;
			num_s2 <= 18'(10'(sd_s1.sum) - 10'(3 * 10'(mn_s1))) * 18'd255;
			if (x0 < 0) begin
				c_s2.x   <= y0;
				c_s2.y   <= -x0;
				c_s2.ang <= QuarterTurn;
			end else begin
				c_s2.x   <= x0;
				c_s2.y   <= y0;
				c_s2.ang <= '0;
			end
		end
	end

	assign v_c[0]   = v_s2;
	assign sd_c[0]  = sd_s2;
	assign c_c[0]   = c_s2;
	assign rem_c[0] = num_s2;
	assign quo_c[0] = '0;

	for (genvar i = 0; i < Stages; i++) begin : g_cordic
		cordic_t nx;
		logic [17:0] rn;
		logic [7:0]  qn;
		logic [17:0] dsh;
		always_comb begin
			nx = c_c[i];
			if (c_c[i].y > 0) begin
				nx.x   = c_c[i].x + shr_tz(c_c[i].y, 5'(i));
				nx.y   = c_c[i].y - shr_tz(c_c[i].x, 5'(i));
				nx.ang = c_c[i].ang + ang_t'(atan_turn(5'(i)));
			end else begin
				nx.x   = c_c[i].x - shr_tz(c_c[i].y, 5'(i));
				nx.y   = c_c[i].y + shr_tz(c_c[i].x, 5'(i));
				nx.ang = c_c[i].ang - ang_t'(atan_turn(5'(i)));
			end
			rn  = rem_c[i];
			qn  = quo_c[i];
			dsh = '0;
			if (i < 8) begin
				dsh = 18'(sd_c[i].sum) << (7 - (i % 8));
				qn  = quo_c[i] << 1;
				if (sd_c[i].sum != 10'd0 && rem_c[i] >= dsh) begin
					rn = rem_c[i] - dsh;
					qn = (quo_c[i] << 1) | 8'd1;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_c[i+1] <= 1'b0;
			end else if (adv) begin
				v_c[i+1] <= v_c[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				c_c[i+1]   <= nx;
				sd_c[i+1]  <= sd_c[i];
				rem_c[i+1] <= rn;
				quo_c[i+1] <= qn;
			end
		end
	end

	// clamp and hue select
	logic  v_s3;
	side_t sd_s3;
	logic [7:0]  sat_s3;
	logic [31:0] hturn_s3;
	ang_t th;
	logic [32:0] ht;

	always_comb begin
		th = c_c[Stages].ang;
		if (th < 0) th = '0;
		if (th > HalfTurn) th = HalfTurn;
		if (sd_c[Stages].gray) th = QuarterTurn;
		if (sd_c[Stages].blue_gt) ht = 33'h100000000 - 33'(th);
		else ht = 33'(th);
		if (ht[32]) ht = 33'h0FFFFFFFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_c[Stages];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s3    <= sd_c[Stages];
			sat_s3   <= (sd_c[Stages].sum == 10'd0) ? 8'd0 : quo_c[Stages];
			hturn_s3 <= ht[31:0];
		end
	end

	logic [39:0] hprod;
	assign hprod = 40'(hturn_s3) * 40'd255;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= {sd_s3.intensity, sat_s3, hprod[39:32]};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");
	a_int: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> sd_s3.sum >= 10'(3 * 10'(sd_s3.intensity)))
		else $error("intensity out of range");

endmodule
